@@ hw/rtl/acac_pkg.sv @@
// ----------------------------------------------------------------------------
// acac_pkg
// Shared types and constants for the address class cache with aging.
// ----------------------------------------------------------------------------
package acac_pkg;

    // opcodes of an input item
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCED_LIMIT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INTERVAL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIFETIME = 4'd3;

    // register reset values
    localparam logic [3:0]  FAIL_LIMIT_RST     = 4'd5;
    localparam logic [9:0]  FORCED_LIMIT_RST   = 10'd100;
    localparam logic [31:0] SWEEP_INTERVAL_RST = 32'd10000;
    localparam logic [31:0] ENTRY_LIFETIME_RST = 32'd3600000;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic        cls;
        logic [31:0] stamp;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic walk_en;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic need_walk;
        logic out_free;
    } ctrl_stat_t;

endpackage

@@ hw/rtl/acac_ctrl.sv @@
// ----------------------------------------------------------------------------
// acac_ctrl
// Sequencer for the cache: clearing pass, table walk, commit of results.
// ----------------------------------------------------------------------------
module acac_ctrl
    import acac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = stat.need_walk ? ST_WALK : ST_COMMIT;
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ hw/rtl/acac_datapath.sv @@
// ----------------------------------------------------------------------------
// acac_datapath
// Entry memory, walk index, match accumulators, counters and result register.
// ----------------------------------------------------------------------------
module acac_datapath
    import acac_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output ctrl_stat_t           stat,
    input  logic [1:0]           opcode,
    input  logic [31:0]          address,
    input  logic                 premium,
    input  logic [31:0]          now_ms,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic                 is_premium,
    output logic                 insert_dropped
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // configuration registers
    logic [3:0]  fail_limit_reg;
    logic [9:0]  forced_limit_reg;
    logic [31:0] sweep_interval_reg;
    logic [31:0] entry_lifetime_reg;

    // item registers
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic        prem_reg;
    logic [31:0] now_reg;
    logic        due_reg;

    // persistent counters
    logic [4:0]  fail_cnt_reg;
    logic [9:0]  forced_cnt_reg;
    logic [31:0] last_sweep_reg;

    // walk state
    entry_t      mem [ENTRIES];
    entry_t      rd_data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic        rd_pend_reg;

    // match accumulators
    logic        hit_plain_reg;
    logic        hit_prem_reg;
    logic        dup_reg;
    logic        free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // result register
    logic        out_valid_reg;
    logic        found_reg;
    logic        is_premium_reg;
    logic        dropped_reg;

    logic        rd_hit;
    logic        kill;
    logic        add_wr;
    logic        force_chk;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t      mem_wdata;
    entry_t      kill_data;
    logic [31:0] since_sweep;
    logic [31:0] entry_age;
    logic [4:0]  fail_base;

    // status to controller
    assign stat.idx_last  = (idx_reg == IDX_LAST);
    assign stat.need_walk = !(op_reg == OP_FAIL) && !((op_reg == OP_TICK) && !due_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign since_sweep = now_ms - last_sweep_reg;
    assign entry_age   = now_reg - rd_data_reg.stamp;

    // per-entry decisions on the registered read
    assign rd_hit = rd_pend_reg && rd_data_reg.valid && (rd_data_reg.key == addr_reg);
    assign kill   = rd_pend_reg && (op_reg == OP_TICK) && due_reg && rd_data_reg.valid
                    && (entry_age >= entry_lifetime_reg);
    assign add_wr = cmd.commit && (op_reg == OP_ADD) && !dup_reg && free_found_reg;

    assign force_chk = (fail_cnt_reg > {1'b0, fail_limit_reg})
                       && (forced_cnt_reg < forced_limit_reg);
    assign fail_base = (fail_cnt_reg > {1'b0, fail_limit_reg}) ? 5'd0 : fail_cnt_reg;

    // memory write select
    always_comb
    begin
        kill_data       = rd_data_reg;
        kill_data.valid = 1'b0;
        mem_we          = cmd.clear_en || kill || add_wr;
        mem_waddr       = idx_reg;
        mem_wdata       = '0;
        priority if (cmd.clear_en)
        begin
            mem_waddr = idx_reg;
            mem_wdata = '0;
        end
        else if (kill)
        begin
            mem_waddr = rd_idx_reg;
            mem_wdata = kill_data;
        end
        else
        begin
            mem_waddr       = free_idx_reg;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = addr_reg;
            mem_wdata.cls   = prem_reg;
            mem_wdata.stamp = now_reg;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.walk_en)
        begin
            rd_data_reg <= mem[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
    end

    // walk index and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.walk_en;
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clear_en || cmd.walk_en)
            begin
                idx_reg <= stat.idx_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            prem_reg <= premium;
            now_reg  <= now_ms;
            due_reg  <= (since_sweep >= sweep_interval_reg);
        end
    end

    // match accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_plain_reg  <= 1'b0;
            hit_prem_reg   <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (cmd.load)
        begin
            hit_plain_reg  <= 1'b0;
            hit_prem_reg   <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (rd_hit && !rd_data_reg.cls)
            begin
                hit_plain_reg <= 1'b1;
            end
            if (rd_hit && rd_data_reg.cls)
            begin
                hit_prem_reg <= 1'b1;
            end
            if (rd_hit && (rd_data_reg.cls == prem_reg))
            begin
                dup_reg <= 1'b1;
            end
            // lowest free slot wins
            if (!rd_data_reg.valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg     <= FAIL_LIMIT_RST;
            forced_limit_reg   <= FORCED_LIMIT_RST;
            sweep_interval_reg <= SWEEP_INTERVAL_RST;
            entry_lifetime_reg <= ENTRY_LIFETIME_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FAIL_LIMIT:     fail_limit_reg     <= cfg_data[3:0];
                CFG_FORCED_LIMIT:   forced_limit_reg   <= cfg_data[9:0];
                CFG_SWEEP_INTERVAL: sweep_interval_reg <= cfg_data[31:0];
                CFG_ENTRY_LIFETIME: entry_lifetime_reg <= cfg_data[31:0];
                default:            ;
            endcase
        end
    end

    // failure, forced and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_cnt_reg   <= '0;
            forced_cnt_reg <= '0;
            last_sweep_reg <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_CHECK:
                begin
                    forced_cnt_reg <= force_chk ? forced_cnt_reg + 10'd1 : 10'd0;
                end
                OP_ADD:
                begin
                    fail_cnt_reg <= '0;
                end
                OP_FAIL:
                begin
                    fail_cnt_reg   <= fail_base + 5'd1;
                    forced_cnt_reg <= '0;
                end
                OP_TICK:
                begin
                    if (due_reg)
                    begin
                        last_sweep_reg <= now_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            found_reg      <= (op_reg == OP_CHECK)
                              && (force_chk || hit_plain_reg || hit_prem_reg);
            is_premium_reg <= (op_reg == OP_CHECK)
                              && !force_chk && !hit_plain_reg && hit_prem_reg;
            dropped_reg    <= (op_reg == OP_ADD) && !dup_reg && !free_found_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign is_premium     = is_premium_reg;
    assign insert_dropped = dropped_reg;

    // checks
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(kill && add_wr))
        else $error("sweep invalidation and add write in the same cycle");

    a_commit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !rd_pend_reg && !cmd.walk_en)
        else $error("commit while a table read is still in flight");

    a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed item did not reach the result register");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !rd_pend_reg && !cmd.clear_en && !mem_we)
        else $error("item loaded while table activity is pending");

endmodule

@@ hw/rtl/address_class_cache_with_aging.sv @@
// ----------------------------------------------------------------------------
// address_class_cache_with_aging
// Cache of 32-bit addresses with a class bit and insert time, aged by sweeps.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   opcode, address, premium, now_ms
//  out      out_valid / out_stall found, is_premium, insert_dropped
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  check, add and a due tick: the result follows a walk of the whole table, as
//  one entry memory read port walks the table one entry per cycle.
//  failure items and ticks inside the sweep interval skip the walk.
//  in_stall drops as the result appears, so one item is in flight at a time.
//  after reset a clearing pass over every entry runs with in_stall high.
//  a waiting result does not block acceptance, but holds the next commit.
// ----------------------------------------------------------------------------
module address_class_cache_with_aging
    import acac_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [31:0]          address,
    input  logic                 premium,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic                 is_premium,
    output logic                 insert_dropped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer
    acac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and counters
    acac_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .address        (address),
        .premium        (premium),
        .now_ms         (now_ms),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .is_premium     (is_premium),
        .insert_dropped (insert_dropped)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address class cache with aging. Items are driven
// through the valid/stall input channel and every result is compared with a
// behavioral copy of the cache kept inside the bench. Directed checks of
// lookup precedence, duplicates, full table, forced checks and sweeps come
// first, then random traffic under several register settings and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import acac_pkg::*;

    localparam int ENTRIES          = 64;
    localparam int CLK_PERIOD       = 20;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 500000;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'd9;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic        premium;
        logic [31:0] now_ms;
    } cache_op_t;

    typedef struct packed {
        logic found;
        logic is_premium;
        logic insert_dropped;
    } cache_answer_t;

    // dut ports
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [1:0]           opcode         = OP_CHECK;
    logic [31:0]          address        = '0;
    logic                 premium        = 1'b0;
    logic [31:0]          now_ms         = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 found;
    logic                 is_premium;
    logic                 insert_dropped;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_DAT_W-1:0] cfg_data       = '0;

    // behavioral copy of the cache
    logic        slot_valid [ENTRIES];
    logic [31:0] slot_key   [ENTRIES];
    logic        slot_cls   [ENTRIES];
    logic [31:0] slot_stamp [ENTRIES];
    logic [4:0]  fail_count    = '0;
    logic [9:0]  forced_run    = '0;
    logic [31:0] last_sweep_ms = '0;
    logic [3:0]  lim_fail      = FAIL_LIMIT_RST;
    logic [9:0]  lim_forced    = FORCED_LIMIT_RST;
    logic [31:0] sweep_gap_ms  = SWEEP_INTERVAL_RST;
    logic [31:0] lifetime_ms   = ENTRY_LIFETIME_RST;

    // bench bookkeeping
    cache_answer_t due_answers [$];
    logic [31:0]   addr_pool [16];
    logic [31:0]   clock_ms        = '0;
    int            items_sent      = 0;
    int            errors          = 0;
    int unsigned   cycle_count     = 0;
    bit            idling_on       = 1'b1;
    int            long_holds_asked = 0;
    int            long_holds_done  = 0;

    address_class_cache_with_aging #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .address        (address),
        .premium        (premium),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .is_premium     (is_premium),
        .insert_dropped (insert_dropped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // apply one item to the cache copy and return the answer it gives
    function automatic cache_answer_t apply_cache_op(input cache_op_t item);
        cache_answer_t ans;
        logic          hit_plain;
        logic          hit_prem;
        logic          dup;
        int            free_slot;
        logic [31:0]   since;
        logic [31:0]   age;
        ans       = '0;
        hit_plain = 1'b0;
        hit_prem  = 1'b0;
        dup       = 1'b0;
        free_slot = -1;
        case (item.opcode)
            OP_CHECK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i] && slot_key[i] == item.address)
                    begin
                        if (slot_cls[i])
                            hit_prem = 1'b1;
                        else
                            hit_plain = 1'b1;
                    end
                end
                // a plain match wins over a premium one
                if (hit_plain)
                    ans.found = 1'b1;
                else if (hit_prem)
                begin
                    ans.found      = 1'b1;
                    ans.is_premium = 1'b1;
                end
                // back end failing: answer a plain hit for a bounded run
                if (fail_count > lim_fail && forced_run < lim_forced)
                begin
                    forced_run     = forced_run + 1'b1;
                    ans.found      = 1'b1;
                    ans.is_premium = 1'b0;
                end
                else
                    forced_run = '0;
            end
            OP_ADD:
            begin
                fail_count = '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i])
                    begin
                        if (slot_key[i] == item.address && slot_cls[i] == item.premium)
                            dup = 1'b1;
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (!dup)
                begin
                    if (free_slot < 0)
                        ans.insert_dropped = 1'b1;
                    else
                    begin
                        slot_valid[free_slot] = 1'b1;
                        slot_key[free_slot]   = item.address;
                        slot_cls[free_slot]   = item.premium;
                        slot_stamp[free_slot] = item.now_ms;
                    end
                end
            end
            OP_FAIL:
            begin
                if (fail_count > lim_fail)
                    fail_count = '0;
                fail_count = fail_count + 1'b1;
                forced_run = '0;
            end
            default:
            begin
                // tick: sweep aged entries unless the last sweep is too recent
                since = item.now_ms - last_sweep_ms;
                if (since >= sweep_gap_ms)
                begin
                    last_sweep_ms = item.now_ms;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        age = item.now_ms - slot_stamp[i];
                        if (slot_valid[i] && age >= lifetime_ms)
                            slot_valid[i] = 1'b0;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    // send one item and record the answer it must produce
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input logic prem, input logic [31:0] now);
        cache_op_t item;
        item.opcode  = op;
        item.address = addr;
        item.premium = prem;
        item.now_ms  = now;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        address  <= addr;
        premium  <= prem;
        now_ms   <= now;
        do @(posedge clk); while (in_stall);
        due_answers.push_back(apply_cache_op(item));
        items_sent++;
    endtask

    // random item; pick < 0 chooses the opcode at random
    task automatic send_random(input int step_max, input int pick);
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] now;
        int          roll;
        if (pick >= 0)
            op = pick[1:0];
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = OP_CHECK;
            else if (roll < 75)
                op = OP_ADD;
            else if (roll < 85)
                op = OP_FAIL;
            else
                op = OP_TICK;
        end
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now  = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        addr = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[4'($urandom_range(0, 15))];
        send_item(op, addr, 1'($urandom_range(0, 1)), now);
    endtask

    // stop offering items and wait for every answer to come back
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (due_answers.size() != 0) @(posedge clk);
    endtask

    // one register write; the caller lowers cfg_valid after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FAIL_LIMIT:     lim_fail     = data[3:0];
            CFG_FORCED_LIMIT:   lim_forced   = data[9:0];
            CFG_SWEEP_INTERVAL: sweep_gap_ms = data;
            CFG_ENTRY_LIFETIME: lifetime_ms  = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] fl, input logic [31:0] fcl,
                             input logic [31:0] si, input logic [31:0] el);
        write_reg(CFG_FAIL_LIMIT, fl);
        write_reg(CFG_FORCED_LIMIT, fcl);
        write_reg(CFG_SWEEP_INTERVAL, si);
        write_reg(CFG_ENTRY_LIFETIME, el);
        cfg_valid <= 1'b0;
    endtask

    // lookup precedence, duplicates, other class, gated and due ticks
    task automatic test_lookup_and_add();
        send_item(OP_CHECK, 32'h0000_0000, 1'b0, 32'd0);
        send_item(OP_ADD,   32'h0000_0000, 1'b0, 32'd0);
        send_item(OP_ADD,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_CHECK, 32'h0000_0000, 1'b1, 32'd0);
        send_item(OP_CHECK, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send_item(OP_ADD,   32'h0000_0000, 1'b0, 32'd55);
        send_item(OP_ADD,   32'h0000_0000, 1'b1, 32'd60);
        send_item(OP_CHECK, 32'h0000_0000, 1'b0, 32'd0);
        send_item(OP_ADD,   32'hFFFF_FFFF, 1'b0, 32'd7);
        send_item(OP_CHECK, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send_item(OP_CHECK, 32'h1234_5678, 1'b0, 32'd0);
        send_item(OP_TICK,  32'h0000_0000, 1'b0, 32'd9999);
        send_item(OP_TICK,  32'h0000_0000, 1'b0, 32'd10000);
        send_item(OP_CHECK, 32'h0000_0000, 1'b0, 32'd0);
        finish_phase();
    endtask

    // failures force plain hits for a bounded run; adds clear the failures
    task automatic test_forced_checks();
        write_reg(CFG_FAIL_LIMIT, 32'd1);
        write_reg(CFG_FORCED_LIMIT, 32'd3);
        cfg_valid <= 1'b0;
        send_item(OP_FAIL, 32'h0, 1'b0, 32'd0);
        send_item(OP_FAIL, 32'h0, 1'b0, 32'd0);
        repeat (5) send_item(OP_CHECK, 32'hDEAD_0000, 1'b0, 32'd0);
        // count already above the limit: wraps back to one
        send_item(OP_FAIL,  32'h0, 1'b0, 32'd0);
        send_item(OP_CHECK, 32'hDEAD_0000, 1'b0, 32'd0);
        send_item(OP_FAIL,  32'h0, 1'b0, 32'd0);
        send_item(OP_ADD,   32'hDEAD_0000, 1'b1, 32'd0);
        send_item(OP_CHECK, 32'hDEAD_0000, 1'b0, 32'd0);
        finish_phase();
    endtask

    // sweep gating, aging and time wrap
    task automatic test_aging_sweep();
        configure(32'd5, 32'd100, 32'd100, 32'd1000);
        send_item(OP_TICK,  32'h0, 1'b0, 32'd10050);
        send_item(OP_ADD,   32'hA5A5_A5A5, 1'b1, 32'd10200);
        send_item(OP_TICK,  32'h0, 1'b0, 32'd11100);
        send_item(OP_CHECK, 32'hA5A5_A5A5, 1'b0, 32'd0);
        send_item(OP_CHECK, 32'h0000_0000, 1'b0, 32'd0);
        send_item(OP_TICK,  32'h0, 1'b0, 32'd11150);
        send_item(OP_TICK,  32'h0, 1'b0, 32'd12300);
        send_item(OP_CHECK, 32'hA5A5_A5A5, 1'b0, 32'd0);
        send_item(OP_ADD,   32'h5A5A_5A5A, 1'b0, 32'hFFFF_FF00);
        send_item(OP_TICK,  32'h0, 1'b0, 32'h0000_0100);
        send_item(OP_CHECK, 32'h5A5A_5A5A, 1'b0, 32'd0);
        finish_phase();
    endtask

    // fill the table, overflow it, then clear it with the smallest settings
    task automatic test_table_full();
        configure(32'd5, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i <= ENTRIES; i++)
            send_item(OP_ADD, 32'h1000_0000 + i, i[0], 32'd40 + i);
        send_item(OP_ADD,   32'h1000_0000, 1'b0, 32'd0);
        send_item(OP_CHECK, 32'h1000_0001, 1'b0, 32'd0);
        send_item(OP_TICK,  32'h0, 1'b0, 32'h0000_0000);
        send_item(OP_TICK,  32'h0, 1'b0, 32'h0000_00FF);
        send_item(OP_CHECK, 32'h1000_0002, 1'b0, 32'd0);
        finish_phase();
        configure(32'd5, 32'd100, 32'd0, 32'd0);
        send_item(OP_TICK,  32'h0, 1'b0, 32'h0000_0100);
        send_item(OP_CHECK, 32'h1000_0002, 1'b0, 32'd0);
        send_item(OP_ADD,   32'h1000_0002, 1'b1, 32'd0);
        finish_phase();
    endtask

    // out-of-range index, oversized data and the register extremes
    task automatic test_register_extremes();
        write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
        write_reg(CFG_FAIL_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_FORCED_LIMIT, 32'hFFFF_FC00);
        cfg_valid <= 1'b0;
        repeat (16) send_item(OP_FAIL, 32'h0, 1'b0, 32'd0);
        send_item(OP_CHECK, 32'hCAFE_F00D, 1'b0, 32'd0);
        finish_phase();
        write_reg(CFG_FAIL_LIMIT, 32'd0);
        write_reg(CFG_FORCED_LIMIT, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_item(OP_FAIL, 32'h0, 1'b0, 32'd0);
        repeat (3) send_item(OP_CHECK, 32'hCAFE_F00D, 1'b0, 32'd0);
        finish_phase();
    endtask

    // random traffic with occasional failure storms followed by checks
    task automatic run_random(input int count, input int step_max);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                repeat (int'(lim_fail) + 1 + $urandom_range(0, 1))
                    send_random(step_max, OP_FAIL);
                repeat ($urandom_range(2, 8)) send_random(step_max, OP_CHECK);
            end
            else
                send_random(step_max, -1);
        end
        finish_phase();
    endtask

    task automatic test_random_traffic();
        configure(32'd2, 32'd6, 32'd200, 32'd3000);
        run_random(100, 150);
        configure(32'd0, 32'd1023, 32'd0, 32'd500);
        run_random(100, 60);
        configure(32'd15, 32'd1, 32'd5000, 32'd20000);
        run_random(100, 400);
        configure($urandom_range(0, 15), $urandom_range(0, 1023),
                  $urandom_range(0, 4000), $urandom_range(0, 20000));
        run_random(100, 200);
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        idling_on = 1'b0;
        long_holds_asked++;
        run_random(40, 100);
    endtask

    // closing stretch without any idling
    task automatic test_steady_stream();
        idling_on = 1'b0;
        run_random(60, 100);
    endtask

    // result side stall: long hold on request, else random bursts
    initial
    begin : result_receiver
        forever
        begin
            @(posedge clk);
            if (long_holds_asked != long_holds_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_holds_done++;
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest expected answer
    always @(posedge clk)
    begin : answer_checker
        cache_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_answers.size() == 0)
            begin
                $error("result item with no expected answer");
                errors++;
            end
            else
            begin
                want = due_answers.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    errors++;
                end
                if (is_premium !== want.is_premium)
                begin
                    $error("is_premium: expected %0d, got %0d", want.is_premium, is_premium);
                    errors++;
                end
                if (insert_dropped !== want.insert_dropped)
                begin
                    $error("insert_dropped: expected %0d, got %0d",
                           want.insert_dropped, insert_dropped);
                    errors++;
                end
            end
        end
    end

    initial
    begin : test_sequence
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_cls[i]   = 1'b0;
            slot_stamp[i] = '0;
        end
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
            addr_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_lookup_and_add();
        test_forced_checks();
        test_aging_sweep();
        test_table_full();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        // let any trailing activity settle
        repeat (ENTRIES + 8) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/acac_pkg.sv
hw/rtl/acac_ctrl.sv
hw/rtl/acac_datapath.sv
hw/rtl/address_class_cache_with_aging.sv
tb/tb_top.sv
